// ===== hw/rtl/pwm_period_and_duty_calculator_core_defines.svh =====
// ----------------------------------------------------------------------------
// PWM calculator assertion macros
// Shorthand for the clocked, reset-gated properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PWM_PERIOD_AND_DUTY_CALCULATOR_CORE_DEFINES_SVH
`define PWM_PERIOD_AND_DUTY_CALCULATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM calculator package
// Field widths, status and operation codes, and the queued command format.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int CLK_W  = 27;
  localparam int FREQ_W = 27;
  localparam int CHAN_W = 2;
  localparam int DUTY_W = 14;
  localparam int STAT_W = 2;

  localparam logic [CLK_W-1:0]  CLK_RESET = 27'd8000000;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_FREQ = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_DUTY = 2'd2;

  typedef enum logic [1:0] {
    OP_SET_FREQ,
    OP_BAD_FREQ,
    OP_SET_DUTY,
    OP_BAD_DUTY
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [FREQ_W-1:0] freq;
    logic [CHAN_W-1:0] chan;
    logic [DUTY_W-1:0] duty;
  } cmd_t;

endpackage

// ===== hw/rtl/pdc_div.sv =====
// ----------------------------------------------------------------------------
// PWM calculator divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdc_div #(
  parameter int NW = 30,
  parameter int DW = 43
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] dsr;
  logic [CW-1:0] count;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    shifted = {rem, quo[NW-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = (shifted >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CW'(NW);
      end else if (count != '0) begin
        count <= count - CW'(1);
        if (count == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (count != '0) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== hw/rtl/pdc_front.sv =====
// ----------------------------------------------------------------------------
// PWM calculator front end
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pdc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      req_type,
  input  logic [pdc_pkg::FREQ_W-1:0] frequency_hz,
  input  logic [pdc_pkg::CHAN_W-1:0] channel,
  input  logic [pdc_pkg::DUTY_W-1:0] duty_hundredths,
  output logic                      q_valid,
  input  logic                      q_pop,
  output pdc_pkg::cmd_t             q_cmd
);

  import pdc_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       cls;

  always_comb begin
    cls.freq = frequency_hz;
    cls.chan = channel;
    cls.duty = duty_hundredths;
    if (req_type == 1'b0) begin
      cls.op = (frequency_hz == '0) ? OP_BAD_FREQ : OP_SET_FREQ;
    end else begin
      cls.op = (duty_hundredths > DUTY_FULL) ? OP_BAD_DUTY : OP_SET_DUTY;
    end
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        fill <= fill + 2'd1;
      end else if (q_pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

endmodule

// ===== hw/rtl/pdc_back.sv =====
// ----------------------------------------------------------------------------
// PWM calculator back end
// Sequences the divisions for each frequency command, keeps the period and
// the clock setting, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module pdc_back #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [pdc_pkg::CLK_W-1:0] cfg_wr_data,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  pdc_pkg::cmd_t             q_cmd,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COUNTER_BITS-1:0]   prescale,
  output logic [COUNTER_BITS-1:0]   period,
  output logic [COUNTER_BITS-1:0]   compare,
  output logic [pdc_pkg::CHAN_W-1:0] out_channel,
  output logic [pdc_pkg::STAT_W-1:0] status
);

  import pdc_pkg::*;

  localparam int CB = COUNTER_BITS;
  localparam int PW = CB + DUTY_W;
  localparam int NW = (PW > CLK_W) ? PW : CLK_W;
  localparam int DW = CB + FREQ_W;
  localparam logic [CB-1:0] LIM = '1;
  localparam int RECIP_SH = PW + 2;
  localparam int RECIP_W  = PW - 11;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SH) / 64'(DUTY_FULL));

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV1,
    S_MUL,
    S_DIV2,
    S_RECIP,
    S_FIX,
    S_FINISH
  } state_t;

  state_t               state;
  cmd_t                 cmd;
  logic [CLK_W-1:0]     clk_hz;
  logic [CB-1:0]        period_value;
  logic [CB-1:0]        p;
  logic                 div_start;
  logic [NW-1:0]        div_dividend;
  logic [DW-1:0]        div_divisor;
  logic                 div_done;
  logic [NW-1:0]        div_quo;
  logic [CB-1:0]        res_presc;
  logic [CB-1:0]        res_per;
  logic [CB-1:0]        res_cmp;
  logic [CHAN_W-1:0]    res_chan;
  logic [STAT_W-1:0]    res_stat;
  logic [DW-1:0]        lim_freq;
  logic [DW-1:0]        p_freq;
  logic [PW-1:0]        duty_prod;
  logic [NW:0]          p_next;
  logic [PW-1:0]        duty_x;
  logic [CB-1:0]        cmp_est;
  logic [PW+RECIP_W-1:0] recip_prod;
  logic [PW-1:0]        cmp_back;
  logic [PW-1:0]        cmp_rem;

  // The duty quotient is estimated by a reciprocal multiplication that is at
  // most one low, and one compare against the remainder corrects it.
  always_comb begin
    lim_freq   = {cmd.freq, {CB{1'b0}}} - DW'(cmd.freq);
    p_freq     = p * cmd.freq;
    duty_prod  = period_value * cmd.duty;
    p_next     = (NW + 1)'(div_quo) + (NW + 1)'(1);
    recip_prod = duty_x * RECIP;
    cmp_back   = cmp_est * DUTY_FULL;
    cmp_rem    = duty_x - cmp_back;
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  pdc_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      div_start    <= 1'b0;
      clk_hz       <= CLK_RESET;
      period_value <= '0;
    end else begin
      div_start <= ((state == S_LOAD) && (cmd.op == OP_SET_FREQ)) || (state == S_MUL);
      if (cfg_wr_en) begin
        clk_hz <= cfg_wr_data;
      end
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          res_presc <= '0;
          res_per   <= period_value;
          res_cmp   <= '0;
          case (cmd.op)
            OP_SET_FREQ: begin
              res_chan     <= '0;
              res_stat     <= ST_OK;
              div_dividend <= NW'(clk_hz);
              div_divisor  <= lim_freq;
              state        <= S_DIV1;
            end
            OP_BAD_FREQ: begin
              res_chan <= '0;
              res_stat <= ST_BAD_FREQ;
              state    <= S_FINISH;
            end
            OP_SET_DUTY: begin
              res_chan <= cmd.chan;
              res_stat <= ST_OK;
              duty_x   <= duty_prod;
              state    <= S_RECIP;
            end
            default: begin
              res_chan <= cmd.chan;
              res_stat <= ST_BAD_DUTY;
              state    <= S_FINISH;
            end
          endcase
        end
        S_DIV1: begin
          if (div_done) begin
            if (p_next >= (NW + 1)'(LIM)) begin
              res_stat <= ST_BAD_FREQ;
              state    <= S_FINISH;
            end else begin
              p     <= p_next[CB-1:0];
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          div_dividend <= NW'(clk_hz);
          div_divisor  <= p_freq;
          state        <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            res_presc    <= p;
            res_per      <= div_quo[CB-1:0];
            period_value <= div_quo[CB-1:0];
            state        <= S_FINISH;
          end
        end
        S_RECIP: begin
          cmp_est <= recip_prod[RECIP_SH +: CB];
          state   <= S_FIX;
        end
        S_FIX: begin
          res_cmp <= (cmp_rem >= PW'(DUTY_FULL)) ? cmp_est + CB'(1) : cmp_est;
          state   <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            prescale    <= res_presc;
            period      <= res_per;
            compare     <= res_cmp;
            out_channel <= res_chan;
            status      <= res_stat;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pwm_period_and_duty_calculator_core.sv =====
// ----------------------------------------------------------------------------
// PWM period and duty calculator
// Finds prescaler and period for a requested frequency, and compare values
// for a requested duty cycle, against a programmable timer clock.
// ----------------------------------------------------------------------------
// A frequency beat runs two divisions on the shared divider, one when no
// prescaler fits; a duty beat runs a reciprocal multiply and a correcting
// compare; a rejected beat goes straight to the result. The divider, of width
// NW = max(27, COUNTER_BITS+14), 30 by default, retires one quotient bit per
// cycle. The back end takes one beat at a time; the front queue holds two.
// Reset: synchronous rst empties the queue, clears the kept period to zero
// and loads the timer clock register with 8000000.
module pwm_period_and_duty_calculator_core #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [pdc_pkg::CLK_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       req_type,
  input  logic [pdc_pkg::FREQ_W-1:0] frequency_hz,
  input  logic [pdc_pkg::CHAN_W-1:0] channel,
  input  logic [pdc_pkg::DUTY_W-1:0] duty_hundredths,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COUNTER_BITS-1:0]    prescale,
  output logic [COUNTER_BITS-1:0]    period,
  output logic [COUNTER_BITS-1:0]    compare,
  output logic [pdc_pkg::CHAN_W-1:0] out_channel,
  output logic [pdc_pkg::STAT_W-1:0] status
);

  import pdc_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  pdc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .frequency_hz    (frequency_hz),
    .channel         (channel),
    .duty_hundredths (duty_hundredths),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_cmd           (q_cmd)
  );

  pdc_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .prescale    (prescale),
    .period      (period),
    .compare     (compare),
    .out_channel (out_channel),
    .status      (status)
  );

endmodule

// ===== hw/rtl/pdc_checker.sv =====
// ----------------------------------------------------------------------------
// PWM calculator port checker
// Watches the result port of the calculator for held beats and for field
// combinations that the status code rules out.
// ----------------------------------------------------------------------------
`include "pwm_period_and_duty_calculator_core_defines.svh"

module pdc_checker #(
  parameter int COUNTER_BITS = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [COUNTER_BITS-1:0]    prescale,
  input logic [COUNTER_BITS-1:0]    period,
  input logic [COUNTER_BITS-1:0]    compare,
  input logic [pdc_pkg::CHAN_W-1:0] out_channel,
  input logic [pdc_pkg::STAT_W-1:0] status
);

  import pdc_pkg::*;

  `PDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(prescale) && $stable(period) && $stable(compare)
    && $stable(out_channel) && $stable(status), "Stalled result beat changed")

  `PDC_ASSERT_NOW(a_bad_freq, out_valid && status == ST_BAD_FREQ,
    prescale == '0 && compare == '0 && out_channel == '0,
    "Invalid frequency beat carries a prescaler, compare or channel")

  `PDC_ASSERT_NOW(a_bad_duty, out_valid && status == ST_BAD_DUTY,
    prescale == '0 && compare == '0, "Invalid duty beat carries a prescaler or compare")

  `PDC_ASSERT_NOW(a_cmp_range, out_valid && status == ST_OK && prescale == '0,
    compare <= period, "Compare value exceeds the kept period")

endmodule

bind pwm_period_and_duty_calculator_core pdc_checker #(
  .COUNTER_BITS (COUNTER_BITS)
) u_pdc_checker (.*);

// ===== bench/pwm_period_and_duty_calculator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM period and duty calculator testbench
// Drives set-frequency and set-duty beats against several timer clock
// settings, predicts each prescaler, period and compare value in the bench,
// and checks every output beat while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module pwm_period_and_duty_calculator_core_test;
  import pdc_pkg::*;

  localparam logic REQ_SET_FREQ = 1'b0;
  localparam logic REQ_SET_DUTY = 1'b1;
  localparam longint unsigned COUNTER_LIMIT = 64'd65535;
  localparam int CLOCK_SETTINGS = 8;
  localparam int BEATS_PER_SETTING = 50;
  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [15:0]       prescale;
    logic [15:0]       period;
    logic [15:0]       compare;
    logic [CHAN_W-1:0] chan;
    logic [STAT_W-1:0] status;
  } pwm_result_t;

  typedef struct packed {
    logic              req;
    logic [FREQ_W-1:0] freq;
    logic [CHAN_W-1:0] chan;
    logic [DUTY_W-1:0] duty;
    logic              typed;
    pwm_result_t       known;
  } settings_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CLK_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = REQ_SET_FREQ;
  logic [FREQ_W-1:0] frequency_hz = '0;
  logic [CHAN_W-1:0] channel = '0;
  logic [DUTY_W-1:0] duty_hundredths = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] prescale;
  logic [15:0] period;
  logic [15:0] compare;
  logic [CHAN_W-1:0] out_channel;
  logic [STAT_W-1:0] status;

  logic [CLK_W-1:0] clock_hz = CLK_RESET;
  logic [15:0] kept_period = '0;
  pwm_result_t awaited_timer_settings[$];
  pwm_result_t oldest_settings;
  int failures = 0;
  int idle_cycles = 0;
  bit send_calm = 1'b0;
  bit stall_calm = 1'b0;

  settings_request_t directed_requests[] = '{
    '{REQ_SET_DUTY, 27'd0, 2'd0, 14'd5000, 1'b1, '{16'd0, 16'd0, 16'd0, 2'd0, ST_OK}},
    '{REQ_SET_FREQ, 27'd0, 2'd0, 14'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 2'd0, ST_BAD_FREQ}},
    '{REQ_SET_DUTY, 27'd0, 2'd3, 14'd16383, 1'b1,
      '{16'd0, 16'd0, 16'd0, 2'd3, ST_BAD_DUTY}},
    '{REQ_SET_FREQ, 27'd1, 2'd0, 14'd0, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd1, 14'd10000, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd2, 14'd0, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd3, 14'd10001, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd0, 14'd1, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd1, 14'd9999, 1'b0, '0},
    '{REQ_SET_FREQ, 27'd0, 2'd2, 14'd100, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd2, 14'd2500, 1'b0, '0},
    '{REQ_SET_FREQ, 27'd1000, 2'd0, 14'd0, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd3, 14'd7500, 1'b0, '0},
    '{REQ_SET_FREQ, 27'd122, 2'd0, 14'd0, 1'b0, '0},
    '{REQ_SET_FREQ, 27'd123, 2'd0, 14'd0, 1'b0, '0},
    '{REQ_SET_FREQ, 27'd8000000, 2'd0, 14'd0, 1'b0, '0},
    '{REQ_SET_FREQ, 27'd8000001, 2'd0, 14'd0, 1'b0, '0},
    '{REQ_SET_FREQ, 27'd72000000, 2'd0, 14'd0, 1'b0, '0},
    '{REQ_SET_FREQ, 27'h7FFFFFF, 2'd3, 14'd16383, 1'b0, '0},
    '{REQ_SET_DUTY, 27'h7FFFFFF, 2'd0, 14'd10000, 1'b0, '0},
    '{REQ_SET_FREQ, 27'd50, 2'd0, 14'd0, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd1, 14'h2AAA, 1'b0, '0},
    '{REQ_SET_DUTY, 27'd0, 2'd3, 14'd5000, 1'b0, '0}
  };

  pwm_period_and_duty_calculator_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .frequency_hz   (frequency_hz),
    .channel        (channel),
    .duty_hundredths(duty_hundredths),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .prescale       (prescale),
    .period         (period),
    .compare        (compare),
    .out_channel    (out_channel),
    .status         (status)
  );

  always #1 clk = ~clk;

  function automatic pwm_result_t compute_timer_settings(input logic req,
                                                         input logic [FREQ_W-1:0] freq,
                                                         input logic [CHAN_W-1:0] chan,
                                                         input logic [DUTY_W-1:0] duty);
    pwm_result_t res;
    longint unsigned scale;
    res = '0;
    res.period = kept_period;
    res.status = ST_OK;
    if (req == REQ_SET_FREQ) begin
      if (freq == '0) begin
        res.status = ST_BAD_FREQ;
      end else begin
        scale = 64'(clock_hz) / (COUNTER_LIMIT * 64'(freq)) + 64'd1;
        if (scale >= COUNTER_LIMIT) begin
          res.status = ST_BAD_FREQ;
        end else begin
          res.prescale = scale[15:0];
          res.period = 16'(64'(clock_hz) / (scale * 64'(freq)));
          kept_period = res.period;
        end
      end
    end else begin
      res.chan = chan;
      if (duty > DUTY_FULL) begin
        res.status = ST_BAD_DUTY;
      end else begin
        res.compare = 16'((64'(kept_period) * 64'(duty)) / 64'(DUTY_FULL));
      end
    end
    return res;
  endfunction

  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  task automatic drive_beat(input logic req, input logic [FREQ_W-1:0] freq,
                            input logic [CHAN_W-1:0] chan,
                            input logic [DUTY_W-1:0] duty,
                            input logic typed, input pwm_result_t known);
    int gap;
    pwm_result_t predicted;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    frequency_hz <= freq;
    channel <= chan;
    duty_hundredths <= duty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = compute_timer_settings(req, freq, chan, duty);
    awaited_timer_settings.push_back(typed ? known : predicted);
  endtask

  task automatic random_beat();
    logic req;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    int roll;
    req = ($urandom_range(0, 99) < 55) ? REQ_SET_DUTY : REQ_SET_FREQ;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      freq = '0;
    end else if (roll < 35) begin
      freq = FREQ_W'($urandom_range(1, 1000));
    end else if (roll < 65) begin
      freq = FREQ_W'($urandom_range(1, 100000));
    end else if (roll < 80 && clock_hz != '0) begin
      freq = FREQ_W'($urandom_range(1, clock_hz));
    end else if (roll < 90) begin
      freq = FREQ_W'($urandom_range(1, 72000000));
    end else begin
      freq = FREQ_W'($urandom());
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      duty = DUTY_W'($urandom_range(0, 10000));
    end else if (roll < 80) begin
      duty = $urandom_range(0, 1) ? DUTY_FULL : '0;
    end else begin
      duty = DUTY_W'($urandom_range(10001, 16383));
    end
    drive_beat(req, freq, 2'($urandom()), duty, 1'b0, '0);
  endtask

  task automatic program_clock(input logic [CLK_W-1:0] hz);
    in_valid <= 1'b0;
    while (awaited_timer_settings.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    clock_hz = hz;
  endtask

  initial begin
    int stall_len;
    @(posedge clk);
    forever begin
      stall_len = pick_gap(stall_calm);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_timer_settings.size() == 0) begin
        $display("%0t: unexpected beat prescale=%0d period=%0d compare=%0d channel=%0d status=%0d",
                 $time, prescale, period, compare, out_channel, status);
        failures++;
      end else begin
        oldest_settings = awaited_timer_settings.pop_front();
        check_field("prescale", 32'(oldest_settings.prescale), 32'(prescale));
        check_field("period", 32'(oldest_settings.period), 32'(period));
        check_field("compare", 32'(oldest_settings.compare), 32'(compare));
        check_field("out_channel", 32'(oldest_settings.chan), 32'(out_channel));
        check_field("status", 32'(oldest_settings.status), 32'(status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [CLK_W-1:0] next_clock;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_requests[i]) begin
      drive_beat(directed_requests[i].req, directed_requests[i].freq,
                 directed_requests[i].chan, directed_requests[i].duty,
                 directed_requests[i].typed, directed_requests[i].known);
    end
    for (int setting = 0; setting < CLOCK_SETTINGS; setting++) begin
      case (setting)
        0: next_clock = 27'd72000000;
        1: next_clock = '0;
        2: next_clock = 27'd1;
        3: next_clock = 27'h7FFFFFF;
        4: next_clock = CLK_W'($urandom_range(1, 72000000));
        5: next_clock = CLK_RESET;
        6: next_clock = CLK_W'($urandom());
        default: next_clock = 27'd1000000;
      endcase
      send_calm = (setting % 3 == 1);
      stall_calm = (setting % 3 == 2);
      program_clock(next_clock);
      repeat (BEATS_PER_SETTING) random_beat();
    end
    in_valid <= 1'b0;
    while (awaited_timer_settings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_div.sv
hw/rtl/pdc_front.sv
hw/rtl/pdc_back.sv
hw/rtl/pwm_period_and_duty_calculator_core.sv
hw/rtl/pdc_checker.sv
bench/pwm_period_and_duty_calculator_core_test.sv
